// ===== sv/wsvs_pkg.sv =====
// Package for the weighted smoothed virtual sensor core.
// Field widths, scale constant, register codes and shared control structs.
// No dependencies.
package wsvs_pkg;

    localparam int SENSOR_COUNT_DEF = 3;
    localparam int FIELD_COUNT      = 3;
    localparam int SCALE            = 1000;

    localparam int READING_W = 18;
    localparam int OFFSET_W  = 16;
    localparam int DIFF_W    = READING_W + 1;
    localparam int SMOOTH_W  = 20;
    localparam int FIELD_W   = 10;
    localparam int PACK_W    = FIELD_COUNT * FIELD_W;
    localparam int OUT_W     = 21;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = FIELD_W + 1 + SMOOTH_W;
    localparam int FIELD_IDX_W = $clog2(FIELD_COUNT);

    localparam int S_TDATA_W = ((FIELD_COUNT * READING_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PACK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TWO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PACK = 3'd4;

    localparam logic [PACK_W-1:0] ALPHA_PACK_RST  = 30'd1049601000;
    localparam logic [PACK_W-1:0] WEIGHT_PACK_RST = 30'd349517133;

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));

    typedef struct packed {
        logic [FIELD_COUNT-1:0][OFFSET_W-1:0] offset;
        logic [FIELD_COUNT-1:0][FIELD_W-1:0]  alpha;
        logic [FIELD_COUNT-1:0][FIELD_W-1:0]  weight;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic en;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/wsvs_cfg.sv =====
// Configuration register file: offsets, saturated alphas and weights.
// Depends on wsvs_pkg.
module wsvs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [wsvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output wsvs_pkg::cfg_t                 cfg
);
    import wsvs_pkg::*;

    logic [FIELD_COUNT-1:0][OFFSET_W-1:0] offset_reg;
    logic [PACK_W-1:0]                    alpha_pack_reg;
    logic [PACK_W-1:0]                    weight_pack_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            alpha_pack_reg  <= ALPHA_PACK_RST;
            weight_pack_reg <= WEIGHT_PACK_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OFFSET_ZERO: offset_reg[0] <= cfg_wdata[OFFSET_W-1:0];
                CFG_OFFSET_ONE:  offset_reg[1] <= cfg_wdata[OFFSET_W-1:0];
                CFG_OFFSET_TWO:  offset_reg[2] <= cfg_wdata[OFFSET_W-1:0];
                CFG_ALPHA_PACK:  alpha_pack_reg <= cfg_wdata[PACK_W-1:0];
                CFG_WEIGHT_PACK: weight_pack_reg <= cfg_wdata[PACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.offset = offset_reg;
        for (int i = 0; i < FIELD_COUNT; i++) begin
            cfg.weight[i] = weight_pack_reg[i*FIELD_W +: FIELD_W];
            if (alpha_pack_reg[i*FIELD_W +: FIELD_W] > FIELD_W'(SCALE)) begin
                cfg.alpha[i] = FIELD_W'(SCALE);
            end else begin
                cfg.alpha[i] = alpha_pack_reg[i*FIELD_W +: FIELD_W];
            end
        end
    end

endmodule

// ===== sv/wsvs_mac.sv =====
// Shared multiply-accumulate unit: unsigned coefficient times signed operand.
// Depends on wsvs_pkg.
module wsvs_mac (
    input  logic                                aclk,
    input  wsvs_pkg::mac_ctrl_t                 ctrl,
    input  logic [wsvs_pkg::FIELD_W-1:0]         coef,
    input  logic signed [wsvs_pkg::SMOOTH_W-1:0] operand,
    output logic signed [wsvs_pkg::ACC_W-1:0]    acc
);
    import wsvs_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        prod = $signed({1'b0, coef}) * operand;
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.en) begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== sv/wsvs_div.sv =====
// Signed divider by the scale constant, truncating toward zero: magnitude times a
// rounded-up reciprocal over three registered steps. Depends on wsvs_pkg.
module wsvs_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [wsvs_pkg::ACC_W-1:0] dividend,
    output wsvs_pkg::div_stat_t              stat,
    output logic signed [wsvs_pkg::ACC_W-1:0] quotient
);
    import wsvs_pkg::*;

    localparam int     MAG_W       = ACC_W - 1;
    localparam int     RECIP_SHIFT = 38;
    localparam int     RECIP_W     = 29;
    localparam int     MUL_W       = MAG_W + RECIP_W;
    localparam int     QUO_W       = MUL_W - RECIP_SHIFT;
    localparam longint RECIP_VAL   = ((64'sd1 <<< RECIP_SHIFT) + SCALE - 1) / SCALE;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic                    mag_vld_reg, mag_vld_next;
    logic                    mul_vld_reg, mul_vld_next;
    logic                    done_reg, done_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [MUL_W-1:0]        prod_reg, prod_next;
    logic signed [ACC_W-1:0] quo_reg, quo_next;
    logic signed [ACC_W-1:0] abs_val;
    logic signed [ACC_W-1:0] quo_mag;

    always_comb begin
        abs_val      = dividend[ACC_W-1] ? -dividend : dividend;
        quo_mag      = {{(ACC_W-QUO_W){1'b0}}, prod_reg[MUL_W-1:RECIP_SHIFT]};
        mag_vld_next = start;
        mul_vld_next = mag_vld_reg;
        done_next    = mul_vld_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        quo_next     = quo_reg;
        if (start) begin
            mag_next = abs_val[MAG_W-1:0];
            neg_next = dividend[ACC_W-1];
        end
        if (mag_vld_reg) begin
            prod_next = MUL_W'(mag_reg) * MUL_W'(RECIP);
        end
        if (mul_vld_reg) begin
            quo_next = neg_reg ? -quo_mag : quo_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            mag_vld_reg <= mag_vld_next;
            mul_vld_reg <= mul_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = mag_vld_reg | mul_vld_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/weighted_smoothed_virtual_sensor_core.sv =====
// Top level of the weighted smoothed virtual sensor: sequencer, state, handshakes.
// Depends on wsvs_pkg, wsvs_cfg, wsvs_mac and wsvs_div.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------
//   s_       | in        | reading_zero, reading_one, reading_two
//   m_       | out       | fused_temp
//   cfg_     | in        | register index and write data, no read-back
//
// Each sensor whose average is nonzero takes two MAC passes and a divide; one
// whose average is zero loads its offset-corrected reading directly. Fusion then
// weights the ACTIVE averages in the MAC and divides by 1000 through the same
// three-step reciprocal divider before the result is posted.
// s_tready is high only between items; a result held in the output register
// while m_tready is low lets the next item start, which then waits to post.
// Reset is synchronous, active low, and clears the averages to zero.
module weighted_smoothed_virtual_sensor_core #(
    parameter int SENSOR_COUNT = wsvs_pkg::SENSOR_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // reading_zero, reading_one, reading_two
    input  logic [wsvs_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fused_temp
    output logic [wsvs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [wsvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import wsvs_pkg::*;

    localparam int ACTIVE = (SENSOR_COUNT < FIELD_COUNT) ? SENSOR_COUNT : FIELD_COUNT;
    localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MAC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_WAIT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           step_reg, step_next;
    logic                       fused_reg, fused_next;
    logic signed [SMOOTH_W-1:0] smooth_reg [ACTIVE];
    logic signed [SMOOTH_W-1:0] smooth_next [ACTIVE];
    logic [READING_W-1:0]       reading_reg [ACTIVE];
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]           out_data_reg, out_data_next;

    cfg_t                       cfg;
    mac_ctrl_t                  mac_ctrl;
    div_stat_t                  div_stat;
    logic [FIELD_W-1:0]         coef;
    logic signed [SMOOTH_W-1:0] operand;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    quotient;
    logic                       div_start;

    logic [IDX_W-1:0]           op_sel;
    logic [FIELD_IDX_W-1:0]     fsel;
    logic [FIELD_IDX_W-1:0]     isel;
    logic signed [SMOOTH_W-1:0] op_val;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SMOOTH_W-1:0] diff_ext;
    logic                       idx_last;
    logic                       mac_last;
    logic [OUT_W-1:0]           sat_val;
    logic                       s_accept;

    wsvs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wsvs_mac u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .coef    (coef),
        .operand (operand),
        .acc     (acc)
    );

    wsvs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        op_sel   = fused_reg ? step_reg : idx_reg;
        fsel     = FIELD_IDX_W'(op_sel);
        isel     = FIELD_IDX_W'(idx_reg);
        op_val   = smooth_reg[op_sel];
        diff     = $signed({reading_reg[idx_reg][READING_W-1], reading_reg[idx_reg]})
                 - $signed({{(DIFF_W-OFFSET_W){cfg.offset[isel][OFFSET_W-1]}},
                            cfg.offset[isel]});
        diff_ext = {{(SMOOTH_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        idx_last = (idx_reg == IDX_W'(ACTIVE - 1));

        if (quotient > OUT_MAX) begin
            sat_val = OUT_MAX[OUT_W-1:0];
        end else if (quotient < OUT_MIN) begin
            sat_val = OUT_MIN[OUT_W-1:0];
        end else begin
            sat_val = quotient[OUT_W-1:0];
        end

        state_next    = state_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        fused_next    = fused_reg;
        smooth_next   = smooth_reg;
        out_data_next = out_data_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        mac_ctrl.clear = (state_reg != ST_MAC);
        mac_ctrl.en    = 1'b0;
        div_start      = 1'b0;
        coef           = cfg.alpha[isel];
        operand        = diff_ext;
        mac_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next   = '0;
                    fused_next = 1'b0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                step_next = '0;
                if (op_val == '0) begin
                    smooth_next[idx_reg] = diff_ext;
                    if (idx_last) begin
                        fused_next = 1'b1;
                        state_next = ST_MAC;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                mac_ctrl.en = 1'b1;
                if (fused_reg) begin
                    coef     = cfg.weight[fsel];
                    operand  = op_val;
                    mac_last = (step_reg == IDX_W'(ACTIVE - 1));
                end else if (step_reg != '0) begin
                    coef     = FIELD_W'(SCALE) - cfg.alpha[isel];
                    operand  = op_val;
                    mac_last = 1'b1;
                end
                if (mac_last) begin
                    state_next = ST_DIV;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    if (fused_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        smooth_next[idx_reg] = quotient[SMOOTH_W-1:0];
                        step_next = '0;
                        if (idx_last) begin
                            fused_next = 1'b1;
                            state_next = ST_MAC;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_data_next = sat_val;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            step_reg    <= '0;
            fused_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ACTIVE; i++) begin
                smooth_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            fused_reg   <= fused_next;
            m_valid_reg <= m_valid_next;
            smooth_reg  <= smooth_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (s_accept) begin
            for (int i = 0; i < ACTIVE; i++) begin
                reading_reg[i] <= s_tdata[i*READING_W +: READING_W];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out_data_reg};

endmodule

// ===== sv/wsvs_checker.sv =====
// Port-level checker for the weighted smoothed virtual sensor core, with its bind.
// Depends on wsvs_pkg and the top level's ports.
module wsvs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wsvs_pkg::M_TDATA_W-1:0] m_tdata
);
    import wsvs_pkg::*;

    logic [M_TDATA_W-1:0] m_tdata_w;
    assign m_tdata_w = m_tdata;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after an accepted item");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared one cycle after its item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata_w)))
        else $error("stalled result changed or dropped");

endmodule

bind weighted_smoothed_virtual_sensor_core wsvs_checker u_wsvs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
